@@ src/sexp_tok_pkg.sv @@
package sexp_tok_pkg;

  localparam int unsigned POS_W = 32;
  localparam int unsigned LEN_W = 16;

  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 16'd256;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;

  typedef enum logic [2:0] {
    TT_OPEN    = 3'd0,
    TT_CLOSE   = 3'd1,
    TT_STRING  = 3'd2,
    TT_NUMBER  = 3'd3,
    TT_IDENT   = 3'd4,
    TT_END     = 3'd5,
    TT_TOOLONG = 3'd6,
    TT_UNTERM  = 3'd7
  } tok_type_t;

  typedef enum logic [3:0] {
    MODE_IDLE   = 4'b0001,
    MODE_STRING = 4'b0010,
    MODE_NUMBER = 4'b0100,
    MODE_IDENT  = 4'b1000
  } lex_mode_t;

  typedef struct packed {
    tok_type_t        token_type;
    logic [POS_W-1:0] token_start;
    logic [LEN_W-1:0] token_length;
    logic             last;
  } result_t;

  // Up to two results per source word, always packed from slot 0.
  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } push_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic continues_ident(input logic [7:0] b);
    return (b >= 8'h21) && (b <= 8'h7E) && (b != CH_OPEN) && (b != CH_CLOSE);
  endfunction

endpackage

@@ src/s_expression_tokenizer_core.sv @@
// A token descriptor is registered in the result queue and presented from its head.
// Throughput: one source word per cycle while in_stall is low; a word that yields two descriptors
// drains them in turn from a four-entry result queue that stalls input at three entries.
// Reset (rst, synchronous, active high): lexer idle, positions and lengths zero, halt
// cleared, queue empty, max_token_len back to 256.
module s_expression_tokenizer_core import sexp_tok_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // source words
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        end_of_input,
  // token descriptors
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  token_type,
  output logic [31:0] token_start,
  output logic [15:0] token_length,
  output logic        last,
  // max_token_len register
  input  logic        cfg_write,
  input  logic [15:0] cfg_data
);

  logic    accept;
  push_t   push;
  result_t head;
  logic    almost_full;

  // Take a word whenever the queue has room for the two results it can cause.
  assign in_stall = almost_full;
  assign accept   = in_valid && !in_stall;

  // Classify the byte, advance lexer state and build up to two descriptors.
  sexp_tok_lexer u_lexer (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .data_byte    (data_byte),
    .end_of_input (end_of_input),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .push         (push)
  );

  // Register descriptors and drain them one per cycle while out_stall is low.
  sexp_tok_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .head        (head),
    .almost_full (almost_full)
  );

  assign token_type   = head.token_type;
  assign token_start  = head.token_start;
  assign token_length = head.token_length;
  assign last         = head.last;

endmodule

@@ src/sexp_tok_lexer.sv @@
module sexp_tok_lexer import sexp_tok_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       data_byte,
  input  logic             end_of_input,
  input  logic             cfg_write,
  input  logic [LEN_W-1:0] cfg_data,
  output push_t            push
);

  lex_mode_t        mode, mode_next;
  logic [POS_W-1:0] open_start, open_start_next;
  logic [LEN_W-1:0] open_len, open_len_next;
  logic [POS_W-1:0] pos, pos_next;
  logic             halted, halted_next;
  logic [LEN_W-1:0] max_len;

  result_t          res [2];
  logic [1:0]       n;
  logic             do_start;
  logic             too_long;

  assign too_long = ({1'b0, open_len} + {{LEN_W{1'b0}}, 1'b1}) > {1'b0, max_len};

  always_comb begin
    mode_next       = mode;
    open_start_next = open_start;
    open_len_next   = open_len;
    pos_next        = pos + {{(POS_W-1){1'b0}}, 1'b1};
    halted_next     = halted;
    res[0]          = '0;
    res[1]          = '0;
    n               = 2'd0;
    do_start        = 1'b0;

    if (end_of_input) begin
      if (!halted && (mode != MODE_IDLE)) begin
        res[0].token_type   = (mode == MODE_NUMBER) ? TT_NUMBER :
                              (mode == MODE_IDENT)  ? TT_IDENT  : TT_UNTERM;
        res[0].token_start  = open_start;
        res[0].token_length = open_len;
        n = 2'd1;
      end
      res[n[0]].token_type   = TT_END;
      res[n[0]].token_start  = pos;
      res[n[0]].token_length = '0;
      n = n + 2'd1;
      mode_next       = MODE_IDLE;
      open_start_next = '0;
      open_len_next   = '0;
      pos_next        = '0;
      halted_next     = 1'b0;
    end else if (!halted) begin
      unique case (mode)
        MODE_STRING: begin
          if (data_byte == CH_QUOTE) begin
            res[0].token_type   = TT_STRING;
            res[0].token_start  = open_start;
            res[0].token_length = open_len;
            n = 2'd1;
            mode_next = MODE_IDLE;
          end else if (too_long) begin
            res[0].token_type   = TT_TOOLONG;
            res[0].token_start  = open_start;
            res[0].token_length = open_len;
            n = 2'd1;
            mode_next   = MODE_IDLE;
            halted_next = 1'b1;
          end else begin
            open_len_next = open_len + {{(LEN_W-1){1'b0}}, 1'b1};
          end
        end
        MODE_NUMBER, MODE_IDENT: begin
          if ((mode == MODE_NUMBER) ? is_digit(data_byte) : continues_ident(data_byte)) begin
            if (too_long) begin
              res[0].token_type   = TT_TOOLONG;
              res[0].token_start  = open_start;
              res[0].token_length = open_len;
              n = 2'd1;
              mode_next   = MODE_IDLE;
              halted_next = 1'b1;
            end else begin
              open_len_next = open_len + {{(LEN_W-1){1'b0}}, 1'b1};
            end
          end else begin
            // Close the token; unless it is whitespace, this byte then opens the next one.
            res[0].token_type   = (mode == MODE_NUMBER) ? TT_NUMBER : TT_IDENT;
            res[0].token_start  = open_start;
            res[0].token_length = open_len;
            n = 2'd1;
            mode_next = MODE_IDLE;
            do_start  = 1'b1;
          end
        end
        MODE_IDLE: do_start = 1'b1;
        default:   do_start = 1'b1;
      endcase

      if (do_start && !is_space(data_byte)) begin
        if (data_byte == CH_QUOTE) begin
          mode_next       = MODE_STRING;
          open_start_next = pos + {{(POS_W-1){1'b0}}, 1'b1};
          open_len_next   = '0;
        end else if (max_len == '0) begin
          res[n[0]].token_type   = TT_TOOLONG;
          res[n[0]].token_start  = pos;
          res[n[0]].token_length = '0;
          n = n + 2'd1;
          mode_next   = MODE_IDLE;
          halted_next = 1'b1;
        end else if ((data_byte == CH_OPEN) || (data_byte == CH_CLOSE)) begin
          res[n[0]].token_type   = (data_byte == CH_OPEN) ? TT_OPEN : TT_CLOSE;
          res[n[0]].token_start  = pos;
          res[n[0]].token_length = {{(LEN_W-1){1'b0}}, 1'b1};
          n = n + 2'd1;
        end else begin
          mode_next       = is_digit(data_byte) ? MODE_NUMBER : MODE_IDENT;
          open_start_next = pos;
          open_len_next   = {{(LEN_W-1){1'b0}}, 1'b1};
        end
      end
    end

    // Mark the final result of this word.
    if (n == 2'd1) begin
      res[0].last = 1'b1;
    end else if (n == 2'd2) begin
      res[1].last = 1'b1;
    end
  end

  assign push.count = accept ? n : 2'd0;
  assign push.res0  = res[0];
  assign push.res1  = res[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      open_start <= '0;
      open_len   <= '0;
      pos        <= '0;
      halted     <= 1'b0;
      max_len    <= MAX_LEN_RESET;
    end else begin
      if (accept) begin
        mode       <= mode_next;
        open_start <= open_start_next;
        open_len   <= open_len_next;
        pos        <= pos_next;
        halted     <= halted_next;
      end
      if (cfg_write) begin
        max_len <= cfg_data;
      end
    end
  end

endmodule

@@ src/sexp_tok_queue.sv @@
module sexp_tok_queue import sexp_tok_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  input  logic    out_stall,
  output logic    out_valid,
  output result_t head,
  output logic    almost_full
);

  result_t    mem [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       pop;

  assign out_valid   = (count != 3'd0);
  assign pop         = out_valid && !out_stall;
  assign head        = mem[rd_ptr];
  // Hold off new words unless two free slots remain.
  assign almost_full = (count > 3'd2);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.res0;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + 2'd1] <= push.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push.count;
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count + {1'b0, push.count} - {2'b00, pop};
    end
  end

endmodule
